[src/ats_pkg.sv]
// Shared types, character codes and helper functions of the assembly token scanner.
package ats_pkg;

	// Width of the line and offset counters; they saturate at all ones.
	localparam int CNT_W = 24;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Result queue depth.
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [3:0] {
		TK_END      = 4'd0,
		TK_NEWLINE  = 4'd1,
		TK_COMMA    = 4'd2,
		TK_COLON    = 4'd3,
		TK_LBRACKET = 4'd4,
		TK_RBRACKET = 4'd5,
		TK_LPAREN   = 4'd6,
		TK_RPAREN   = 4'd7,
		TK_PLUS     = 4'd8,
		TK_MINUS    = 4'd9,
		TK_STAR     = 4'd10,
		TK_SLASH    = 4'd11,
		TK_STRING   = 4'd12,
		TK_NUMBER   = 4'd13,
		TK_IDENT    = 4'd14,
		TK_DIAG     = 4'd15
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_BAD_CHAR  = 2'd1,
		ERR_UNCLOSED  = 2'd2,
		ERR_EMPTY_HEX = 2'd3
	} err_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [31:0] value;
		logic [23:0] line;
		logic [23:0] start;
		logic [23:0] len;
		err_t        err;
		logic        last;
	} tok_t;

	// Tokens handed from the scanner to the result queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       w0;
		tok_t       w1;
	} push_t;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_UP_H    = 8'h48;
	localparam logic [7:0] CH_UP_X    = 8'h58;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_LO_H    = 8'h68;
	localparam logic [7:0] CH_LO_X    = 8'h78;
	localparam logic [7:0] CH_LO_Z    = 8'h7A;

	function automatic logic char_is_num(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic char_is_word(input logic [7:0] c);
		return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
			(c == CH_UNDER) || (c == CH_DOT) || (c == CH_DOLLAR);
	endfunction

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (char_is_num(c))
			r = {1'b1, 4'(c - CH_ZERO)};
		else if ((c >= CH_LO_A) && (c <= CH_LO_F))
			r = {1'b1, 4'(c - CH_LO_A + 8'd10)};
		else if ((c >= CH_UP_A) && (c <= CH_UP_F))
			r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : CNT_W'(v + CNT_W'(1));
	endfunction

	function automatic logic [CNT_W-1:0] span(input logic [CNT_W-1:0] from,
		input logic [CNT_W-1:0] to);
		return (to >= from) ? CNT_W'(to - from) : '0;
	endfunction

	function automatic tok_t mk_tok(input tok_kind_t kind, input logic [31:0] value,
		input logic [CNT_W-1:0] line, input logic [CNT_W-1:0] start,
		input logic [CNT_W-1:0] len, input err_t err);
		tok_t t;
		t.kind  = kind;
		t.value = value;
		t.line  = 24'(line);
		t.start = 24'(start);
		t.len   = 24'(len);
		t.err   = err;
		t.last  = 1'b0;
		return t;
	endfunction

endpackage

[src/ats_fifo.sv]
// Result queue: takes up to two tokens per cycle and hands out one per cycle when popped.
module ats_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  ats_pkg::push_t push,
	input  logic          pop,
	output ats_pkg::tok_t head,
	output logic          not_empty,
	output logic          room2
);
	import ats_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [OCC_W-1:0] occ_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (occ_q != '0);
	assign room2     = (occ_q <= OCC_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
		end else begin
			wr_q  <= PTR_W'(wr_q + PTR_W'(push.cnt));
			if (pop)
				rd_q <= PTR_W'(rd_q + PTR_W'(1));
			occ_q <= OCC_W'(occ_q + OCC_W'(push.cnt) - {{(OCC_W-1){1'b0}}, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_q] <= push.w0;
		if (push.cnt == 2'd2)
			mem_q[PTR_W'(wr_q + PTR_W'(1))] <= push.w1;
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(FIFO_DEPTH)) else $error("result queue overfilled");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty result queue");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (room2 && push.cnt != 2'd3))
		else $error("push without room for two tokens");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |=> not_empty) else $error("pushed token not visible");

endmodule

[src/ats_lexer.sv]
// Scanner state and per-byte token logic; yields up to two tokens per accepted byte.
module ats_lexer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     source_byte,
	input  logic           end_of_input,
	output ats_pkg::push_t push
);
	import ats_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE,
		M_COMMENT,
		M_STRING,
		M_IDENT,
		M_DEC,
		M_CHEX
	} mode_t;

	mode_t            mode_q, n_mode;
	logic             qs_q, n_qs;
	logic [CNT_W-1:0] line_q, n_line;
	logic [CNT_W-1:0] pos_q, n_pos;
	logic [CNT_W-1:0] tstart_q, n_tstart;
	logic [31:0]      hacc_q, n_hacc;
	logic [31:0]      dacc_q, n_dacc;
	logic             hseen_q, n_hseen;
	logic             fin_q, n_fin;

	logic [4:0] hv;
	logic       dig, alp;
	logic       do_flush, do_begin, stop;
	logic       a_vld, b_vld;
	tok_t       tok_a, tok_b;
	tok_kind_t  bk;
	err_t       berr;

	always_comb begin
		n_mode   = mode_q;
		n_qs     = qs_q;
		n_line   = line_q;
		n_pos    = pos_q;
		n_tstart = tstart_q;
		n_hacc   = hacc_q;
		n_dacc   = dacc_q;
		n_hseen  = hseen_q;
		n_fin    = fin_q;
		hv       = hex_val(source_byte);
		dig      = char_is_num(source_byte);
		alp      = char_is_word(source_byte);
		do_flush = 1'b0;
		do_begin = 1'b0;
		a_vld    = 1'b0;
		b_vld    = 1'b0;
		bk       = TK_END;
		berr     = ERR_NONE;
		tok_a    = mk_tok(TK_END, '0, '0, '0, '0, ERR_NONE);
		tok_b    = mk_tok(TK_END, '0, '0, '0, '0, ERR_NONE);
		stop     = fin_q || end_of_input;

		if (stop) begin
			do_flush = !fin_q;
			n_fin    = 1'b1;
		end else begin
			n_pos = sat_inc(pos_q);
			unique case (mode_q)
				M_COMMENT: begin
					if (source_byte == CH_LF)
						do_begin = 1'b1;
				end
				M_STRING: begin
					if (source_byte == (qs_q ? CH_SQUOTE : CH_DQUOTE)) begin
						a_vld  = 1'b1;
						tok_a  = mk_tok(TK_STRING, '0, line_q, tstart_q,
							span(tstart_q, pos_q), ERR_NONE);
						n_mode = M_IDLE;
					end else if (source_byte == CH_LF) begin
						n_line = sat_inc(line_q);
					end
				end
				M_IDENT: begin
					if (!(alp || dig)) begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				M_DEC: begin
					if (hv[4]) begin
						n_hacc = {hacc_q[27:0], hv[3:0]};
						if (dig)
							n_dacc = (dacc_q << 3) + (dacc_q << 1) + {28'b0, hv[3:0]};
						n_hseen = 1'b1;
					end else if ((source_byte == CH_LO_X || source_byte == CH_UP_X) &&
						!hseen_q && hacc_q == '0) begin
						n_mode  = M_CHEX;
						n_hacc  = '0;
						n_hseen = 1'b0;
					end else if (source_byte == CH_LO_H || source_byte == CH_UP_H) begin
						// MASM hex: the suffix is part of the lexeme
						a_vld  = 1'b1;
						tok_a  = mk_tok(TK_NUMBER, hacc_q, line_q, tstart_q,
							span(tstart_q, sat_inc(pos_q)), ERR_NONE);
						n_mode = M_IDLE;
					end else begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				M_CHEX: begin
					if (hv[4]) begin
						n_hacc  = {hacc_q[27:0], hv[3:0]};
						n_hseen = 1'b1;
					end else begin
						do_flush = 1'b1;
						do_begin = 1'b1;
					end
				end
				default: do_begin = 1'b1;
			endcase
		end

		// Close the pending token before the current byte is looked at on its own.
		if (do_flush) begin
			unique case (mode_q)
				M_IDENT: begin
					a_vld = 1'b1;
					tok_a = mk_tok(TK_IDENT, '0, line_q, tstart_q,
						span(tstart_q, pos_q), ERR_NONE);
				end
				M_DEC: begin
					a_vld = 1'b1;
					tok_a = mk_tok(TK_NUMBER, dacc_q, line_q, tstart_q,
						span(tstart_q, pos_q), ERR_NONE);
				end
				M_CHEX: begin
					a_vld = 1'b1;
					tok_a = mk_tok(TK_NUMBER, hacc_q, line_q, tstart_q,
						span(tstart_q, pos_q), hseen_q ? ERR_NONE : ERR_EMPTY_HEX);
				end
				M_STRING: begin
					a_vld = 1'b1;
					tok_a = mk_tok(TK_STRING, '0, line_q, tstart_q,
						span(tstart_q, pos_q), ERR_UNCLOSED);
				end
				default: a_vld = 1'b0;
			endcase
			n_mode = M_IDLE;
		end

		if (stop) begin
			b_vld  = 1'b1;
			tok_b  = mk_tok(TK_END, '0, line_q, pos_q, '0, ERR_NONE);
			n_mode = M_IDLE;
		end

		if (do_begin) begin
			n_mode = M_IDLE;
			unique case (source_byte)
				CH_SPACE, CH_TAB, CH_CR: b_vld = 1'b0;
				CH_SEMI: n_mode = M_COMMENT;
				CH_LF: begin
					b_vld  = 1'b1;
					bk     = TK_NEWLINE;
					n_line = sat_inc(line_q);
				end
				CH_COMMA: begin b_vld = 1'b1; bk = TK_COMMA; end
				CH_COLON: begin b_vld = 1'b1; bk = TK_COLON; end
				CH_LBRACK: begin b_vld = 1'b1; bk = TK_LBRACKET; end
				CH_RBRACK: begin b_vld = 1'b1; bk = TK_RBRACKET; end
				CH_LPAREN: begin b_vld = 1'b1; bk = TK_LPAREN; end
				CH_RPAREN: begin b_vld = 1'b1; bk = TK_RPAREN; end
				CH_PLUS: begin b_vld = 1'b1; bk = TK_PLUS; end
				CH_MINUS: begin b_vld = 1'b1; bk = TK_MINUS; end
				CH_STAR: begin b_vld = 1'b1; bk = TK_STAR; end
				CH_SLASH: begin b_vld = 1'b1; bk = TK_SLASH; end
				CH_DQUOTE, CH_SQUOTE: begin
					n_mode   = M_STRING;
					n_qs     = (source_byte == CH_SQUOTE);
					n_tstart = sat_inc(pos_q);
				end
				default: begin
					if (dig) begin
						n_mode   = M_DEC;
						n_tstart = pos_q;
						n_hacc   = {28'b0, hv[3:0]};
						n_dacc   = {28'b0, hv[3:0]};
						n_hseen  = 1'b0;
					end else if (alp) begin
						n_mode   = M_IDENT;
						n_tstart = pos_q;
					end else begin
						b_vld = 1'b1;
						bk    = TK_DIAG;
						berr  = ERR_BAD_CHAR;
					end
				end
			endcase
			if (b_vld)
				tok_b = mk_tok(bk, '0, line_q, pos_q, CNT_W'(1), berr);
		end

		tok_a.last = !b_vld;
		tok_b.last = 1'b1;

		push.cnt = accept ? (2'({1'b0, a_vld}) + 2'({1'b0, b_vld})) : 2'd0;
		push.w0  = a_vld ? tok_a : tok_b;
		push.w1  = tok_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			qs_q     <= 1'b0;
			line_q   <= CNT_W'(1);
			pos_q    <= '0;
			tstart_q <= '0;
			hacc_q   <= '0;
			dacc_q   <= '0;
			hseen_q  <= 1'b0;
			fin_q    <= 1'b0;
		end else if (accept) begin
			mode_q   <= n_mode;
			qs_q     <= n_qs;
			line_q   <= n_line;
			pos_q    <= n_pos;
			tstart_q <= n_tstart;
			hacc_q   <= n_hacc;
			dacc_q   <= n_dacc;
			hseen_q  <= n_hseen;
			fin_q    <= n_fin;
		end
	end

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q) else $error("end state left");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (mode_q == M_IDLE)) else $error("token pending after end");
	a_end_sets_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_input) |=> fin_q) else $error("end marker not recorded");
	a_pos_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> $stable(pos_q)) else $error("offset moved after end");

endmodule

[src/assembly_token_scanner_unit.sv]
// Top level of the assembly token scanner: byte input, token output through a result queue.
// The scanner takes one source byte per cycle unless stalled and answers each byte with
// zero, one or two tokens, the last one marked with last_result. The tokens of an accepted
// byte are written into a four-entry queue at the accepting edge; when the queue is empty
// the first of them is on the output in the next cycle, and the queue hands out one token
// per cycle while out_stall is low. A byte is accepted whenever at least two queue entries
// are free, so with the output never stalled bytes are accepted back to back as long as
// each yields at most one token; a run of bytes that yield two tokens each is held back by
// the one-token output. No clearing pass is needed after reset.
module assembly_token_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [31:0] number_value,
	output logic [23:0] line_number,
	output logic [23:0] start_offset,
	output logic [23:0] lexeme_length,
	output logic [1:0]  error_code,
	output logic        last_result
);
	import ats_pkg::*;

	push_t push;
	tok_t  head;
	logic  room2;
	logic  accept;
	logic  pop;

	assign in_stall = !room2;
	assign accept   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	ats_lexer u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.source_byte  (source_byte),
		.end_of_input (end_of_input),
		.push         (push)
	);

	ats_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.room2     (room2)
	);

	assign token_kind    = head.kind;
	assign number_value  = head.value;
	assign line_number   = head.line;
	assign start_offset  = head.start;
	assign lexeme_length = head.len;
	assign error_code    = head.err;
	assign last_result   = head.last;

endmodule

[dv/scan_checker.sv]
// Token stream checker: predicts the scanner's tokens from accepted source bytes and compares them.
module scan_checker
	import ats_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  token_kind,
	input  logic [31:0] number_value,
	input  logic [23:0] line_number,
	input  logic [23:0] start_offset,
	input  logic [23:0] lexeme_length,
	input  logic [1:0]  error_code,
	input  logic        last_result,
	output int          fail_count,
	output int          tokens_waiting
);

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_COMMENT,
		SC_STRING,
		SC_WORD,
		SC_DEC,
		SC_HEX
	} scan_state_t;

	scan_state_t mode = SC_IDLE;
	logic        quote_single = 1'b0;
	logic [23:0] line_cnt = 24'd1;
	logic [23:0] pos = '0;
	logic [23:0] lex_start = '0;
	logic [31:0] hex_acc = '0;
	logic [31:0] dec_acc = '0;
	logic        hex_seen = 1'b0;
	logic        finished = 1'b0;

	tok_t step_out [2];
	int   step_cnt;
	tok_t tokens_due [$];
	int   fails = 0;
	int   due_count = 0;

	assign fail_count     = fails;
	assign tokens_waiting = due_count;

	function automatic logic [23:0] sat_up(input logic [23:0] v);
		return (v == '1) ? v : v + 24'd1;
	endfunction

	function automatic logic [23:0] gap(input logic [23:0] from, input logic [23:0] to);
		return (to >= from) ? to - from : '0;
	endfunction

	function automatic logic dec_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | 8'h20;
		return ((lc >= CH_LO_A) && (lc <= CH_LO_Z)) || (c == CH_UNDER) || (c == CH_DOT) ||
			(c == CH_DOLLAR);
	endfunction

	function automatic logic hex_char(input logic [7:0] c, output logic [3:0] v);
		logic [7:0] lc;
		lc = c | 8'h20;
		v = '0;
		if (dec_char(c)) begin
			v = c[3:0];
			return 1'b1;
		end
		if ((lc >= CH_LO_A) && (lc <= CH_LO_F)) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic add_token(input tok_kind_t kind, input logic [31:0] value,
		input logic [23:0] line, input logic [23:0] start, input logic [23:0] len,
		input err_t err);
		tok_t t;
		t.kind  = kind;
		t.value = value;
		t.line  = line;
		t.start = start;
		t.len   = len;
		t.err   = err;
		t.last  = 1'b0;
		if (step_cnt < 2) begin
			step_out[step_cnt] = t;
			step_cnt++;
		end
	endtask

	// Start whatever the byte begins while nothing is pending.
	task automatic open_lexeme(input logic [7:0] c);
		logic [23:0] p;
		p = pos;
		case (c)
			CH_SPACE, CH_TAB, CH_CR: ;
			CH_SEMI: mode = SC_COMMENT;
			CH_LF: begin
				add_token(TK_NEWLINE, '0, line_cnt, p, 24'd1, ERR_NONE);
				line_cnt = sat_up(line_cnt);
			end
			CH_COMMA:  add_token(TK_COMMA, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_COLON:  add_token(TK_COLON, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_LBRACK: add_token(TK_LBRACKET, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_RBRACK: add_token(TK_RBRACKET, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_LPAREN: add_token(TK_LPAREN, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_RPAREN: add_token(TK_RPAREN, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_PLUS:   add_token(TK_PLUS, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_MINUS:  add_token(TK_MINUS, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_STAR:   add_token(TK_STAR, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_SLASH:  add_token(TK_SLASH, '0, line_cnt, p, 24'd1, ERR_NONE);
			CH_DQUOTE, CH_SQUOTE: begin
				mode = SC_STRING;
				quote_single = (c == CH_SQUOTE);
				lex_start = sat_up(p);
			end
			default: begin
				if (dec_char(c)) begin
					mode = SC_DEC;
					lex_start = p;
					hex_acc = 32'(c[3:0]);
					dec_acc = 32'(c[3:0]);
					hex_seen = 1'b0;
				end else if (word_char(c)) begin
					mode = SC_WORD;
					lex_start = p;
				end else begin
					add_token(TK_DIAG, '0, line_cnt, p, 24'd1, ERR_BAD_CHAR);
				end
			end
		endcase
	endtask

	task automatic close_lexeme();
		logic [23:0] len;
		len = gap(lex_start, pos);
		case (mode)
			SC_WORD:   add_token(TK_IDENT, '0, line_cnt, lex_start, len, ERR_NONE);
			SC_DEC:    add_token(TK_NUMBER, dec_acc, line_cnt, lex_start, len, ERR_NONE);
			SC_HEX:    add_token(TK_NUMBER, hex_acc, line_cnt, lex_start, len,
				hex_seen ? ERR_NONE : ERR_EMPTY_HEX);
			SC_STRING: add_token(TK_STRING, '0, line_cnt, lex_start, len, ERR_UNCLOSED);
			default: ;
		endcase
		mode = SC_IDLE;
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic eoi);
		logic       is_hex;
		logic [3:0] nib;
		step_cnt = 0;
		if (finished || eoi) begin
			if (!finished)
				close_lexeme();
			add_token(TK_END, '0, line_cnt, pos, '0, ERR_NONE);
			finished = 1'b1;
			mode = SC_IDLE;
		end else begin
			is_hex = hex_char(c, nib);
			case (mode)
				SC_COMMENT: begin
					if (c == CH_LF) begin
						mode = SC_IDLE;
						open_lexeme(c);
					end
				end
				SC_STRING: begin
					if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
						add_token(TK_STRING, '0, line_cnt, lex_start, gap(lex_start, pos),
							ERR_NONE);
						mode = SC_IDLE;
					end else if (c == CH_LF) begin
						line_cnt = sat_up(line_cnt);
					end
				end
				SC_WORD: begin
					if (!(word_char(c) || dec_char(c))) begin
						close_lexeme();
						open_lexeme(c);
					end
				end
				SC_DEC: begin
					if (is_hex) begin
						hex_acc = {hex_acc[27:0], nib};
						if (dec_char(c))
							dec_acc = dec_acc * 32'd10 + 32'(c[3:0]);
						hex_seen = 1'b1;
					end else if ((c == CH_LO_X || c == CH_UP_X) && !hex_seen &&
						hex_acc == '0) begin
						mode = SC_HEX;
						hex_acc = '0;
						hex_seen = 1'b0;
					end else if (c == CH_LO_H || c == CH_UP_H) begin
						// suffix counts toward the lexeme
						add_token(TK_NUMBER, hex_acc, line_cnt, lex_start,
							gap(lex_start, sat_up(pos)), ERR_NONE);
						mode = SC_IDLE;
					end else begin
						close_lexeme();
						open_lexeme(c);
					end
				end
				SC_HEX: begin
					if (is_hex) begin
						hex_acc = {hex_acc[27:0], nib};
						hex_seen = 1'b1;
					end else begin
						close_lexeme();
						open_lexeme(c);
					end
				end
				default: begin
					mode = SC_IDLE;
					open_lexeme(c);
				end
			endcase
			pos = sat_up(pos);
		end
		if (step_cnt > 0)
			step_out[step_cnt-1].last = 1'b1;
		for (int i = 0; i < step_cnt; i++)
			tokens_due.push_back(step_out[i]);
	endtask

	task automatic check_token();
		tok_t want;
		tok_t got;
		got.kind  = tok_kind_t'(token_kind);
		got.value = number_value;
		got.line  = line_number;
		got.start = start_offset;
		got.len   = lexeme_length;
		got.err   = err_t'(error_code);
		got.last  = last_result;
		if (tokens_due.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected token: kind %0d value %h line %0d start %0d len %0d err %0d",
					got.kind, got.value, got.line, got.start, got.len, got.err);
		end else begin
			want = tokens_due.pop_front();
			if (got.kind !== want.kind || got.value !== want.value ||
				got.line !== want.line || got.start !== want.start ||
				got.len !== want.len || got.err !== want.err || got.last !== want.last) begin
				fails++;
				if (fails <= 10) begin
					$display("token mismatch: expected kind %0d value %h line %0d start %0d len %0d err %0d last %b",
						want.kind, want.value, want.line, want.start, want.len, want.err,
						want.last);
					$display("                got      kind %0d value %h line %0d start %0d len %0d err %0d last %b",
						got.kind, got.value, got.line, got.start, got.len, got.err, got.last);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				scan_byte(source_byte, end_of_input);
			if (out_valid && !out_stall)
				check_token();
			due_count = tokens_due.size();
		end
	end

endmodule

[dv/testbench.sv]
// Testbench top: feeds assembly source bytes to the token scanner and reports the verdict.
module testbench;
	import ats_pkg::*;

	localparam int RANDOM_BYTES   = 1700;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam string WORD_HEAD   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_.$";
	localparam string WORD_TAIL   = "ABCXYZabchqxz_.$0123456789";
	localparam string DEC_DIGITS  = "0123456789";
	localparam string HEX_DIGITS  = "0123456789abcdefABCDEF";
	localparam string HEX_LETTERS = "abcdef";
	localparam string CUT_LETTERS = "gijklmnopqrstuvwxyzGIJKLMNOPQRSTUVWXYZ_.$";
	localparam string PUNCT       = ",:[]()+-*/";
	localparam string BLANKS      = " \t\r";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  source_byte = '0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  token_kind;
	logic [31:0] number_value;
	logic [23:0] line_number;
	logic [23:0] start_offset;
	logic [23:0] lexeme_length;
	logic [1:0]  error_code;
	logic        last_result;

	int fail_count;
	int tokens_waiting;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;

	logic [7:0] frag [$];

	// blanks, comment with a zero byte, every punctuator, bad bytes, empty 0x,
	// MASM hex, number cut by a letter, quoted string spanning a line
	logic [7:0] opening [31] = '{
		CH_SPACE, CH_TAB, CH_CR, CH_SEMI, 8'h00, CH_LF,
		CH_COMMA, CH_COLON, CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
		CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		8'h00, 8'hFF, CH_ZERO, CH_LO_X, CH_SPACE,
		8'h31, CH_LO_F, CH_LO_H, CH_NINE, 8'h67,
		CH_SQUOTE, 8'h61, 8'h00, CH_LF, CH_SQUOTE
	};

	always #10 clk = ~clk;

	assembly_token_scanner_unit u_top (.*);

	scan_checker u_checker (.*);

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < sink_stall_pct);

	// Count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= b;
		end_of_input <= eoi;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic build_fragment();
		int sel;
		int n;
		logic [7:0] q;
		logic [7:0] c;
		frag.delete();
		sel = $urandom_range(99);
		if (sel < 20) begin
			frag.push_back(pick(WORD_HEAD));
			repeat ($urandom_range(6)) frag.push_back(pick(WORD_TAIL));
		end else if (sel < 30) begin
			// long runs wrap the value; a-f letters are skipped by decimal
			n = ($urandom_range(4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
			frag.push_back(pick(DEC_DIGITS));
			repeat (n - 1)
				frag.push_back(($urandom_range(5) == 0) ? pick(HEX_LETTERS) : pick(DEC_DIGITS));
		end else if (sel < 38) begin
			frag.push_back(CH_ZERO);
			frag.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
			n = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 10);
			repeat (n) frag.push_back(pick(HEX_DIGITS));
		end else if (sel < 44) begin
			frag.push_back(pick(DEC_DIGITS));
			repeat ($urandom_range(9)) frag.push_back(pick(HEX_DIGITS));
			frag.push_back($urandom_range(1) ? CH_LO_H : CH_UP_H);
		end else if (sel < 48) begin
			repeat ($urandom_range(1, 3)) frag.push_back(pick(DEC_DIGITS));
			frag.push_back(pick(CUT_LETTERS));
		end else if (sel < 57) begin
			q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
			frag.push_back(q);
			repeat ($urandom_range(8)) begin
				c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(32, 126));
				if ($urandom_range(9) == 0)
					c = CH_LF;
				frag.push_back((c == q) ? CH_SPACE : c);
			end
			frag.push_back(q);
		end else if (sel < 70) begin
			frag.push_back(pick(PUNCT));
		end else if (sel < 78) begin
			repeat ($urandom_range(1, 3)) frag.push_back(pick(BLANKS));
		end else if (sel < 85) begin
			frag.push_back(CH_LF);
		end else if (sel < 92) begin
			frag.push_back(CH_SEMI);
			repeat ($urandom_range(8)) begin
				c = 8'($urandom_range(255));
				frag.push_back((c == CH_LF) ? CH_SPACE : c);
			end
			frag.push_back(CH_LF);
		end else begin
			repeat ($urandom_range(1, 2)) frag.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(1))
			frag.push_back(CH_SPACE);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_byte(opening[i], 1'b0);

		for (int round = 0; round < 8; round++) begin
			case (round % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
				default: begin src_idle_pct = 16; sink_stall_pct = 16; end
			endcase
			while (bytes_sent < (round + 1) * RANDOM_BYTES / 8) begin
				build_fragment();
				foreach (frag[i])
					send_byte(frag[i], 1'b0);
			end
		end

		// string left open at the end of input, then bytes after the end token
		send_byte(CH_DQUOTE, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(8'($urandom_range(255)), 1'b1);
		send_byte(8'($urandom_range(255)), 1'b0);
		repeat (3) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		in_valid <= 1'b0;

		while (tokens_waiting != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
